/* rtl/core/assert_macros.svh */
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ROT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Checked at every edge, reset included.
`define ROT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`endif

/* rtl/core/rot_pkg.sv */
// Types and constants of the relay over-limit trip bank.
package rot_pkg;

    localparam int BITS_PER_BOARD = 8;

    typedef enum logic [1:0] {
        FUNC_READING = 2'd0,
        FUNC_SWITCH  = 2'd1,
        FUNC_RULE    = 2'd2,
        FUNC_UNUSED  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STATUS_DONE    = 2'd0,
        STATUS_BAD_CH  = 2'd1,
        STATUS_NACK    = 2'd2,
        STATUS_IGNORED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_ACTIVE_LOW    = 2'd0,
        CFG_DEFAULT_GRACE = 2'd1,
        CFG_DEFAULT_TRIP  = 2'd2,
        CFG_CHANNELS_USED = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic        active_low;
        logic [31:0] default_grace_ms;
        logic [31:0] default_trip_ms;
        logic [4:0]  channels_in_use;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         func;
        logic [4:0]         channel;
        logic               switch_closed;
        logic [31:0]        energy_wh;
        logic [23:0]        power_w;
        logic [31:0]        now_ms;
        logic               bus_ack;
        logic signed [31:0] energy_limit;
        logic signed [24:0] power_limit;
        logic [31:0]        grace_ms;
        logic [31:0]        trip_ms;
    } t_item;

    // One channel's rule and limiter timing.
    typedef struct packed {
        logic               tripped;
        logic               warned;
        logic [31:0]        exceed_start;
        logic [31:0]        warn_start;
        logic signed [31:0] energy_limit;
        logic signed [24:0] power_limit;
        logic [31:0]        grace_ms;
        logic [31:0]        trip_ms;
    } t_chan_rec;

    localparam t_chan_rec REC_RESET = '{
        tripped:      1'b0,
        warned:       1'b0,
        exceed_start: 32'd0,
        warn_start:   32'd0,
        energy_limit: -32'sd1,
        power_limit:  -25'sd1,
        grace_ms:     32'd0,
        trip_ms:      32'd0
    };

    typedef struct packed {
        logic      chan_we;
        t_chan_rec chan_rec;
        logic      board_we;
        logic [BITS_PER_BOARD-1:0] shadow;
        logic      healthy;
    } t_update;

    typedef struct packed {
        logic [1:0] status;
        logic       bus_write;
        logic       bus_board;
        logic [7:0] bus_byte;
        logic       channel_closed;
        logic       channel_tripped;
        logic       warning_event;
        logic       trip_event;
        logic       board_ok;
    } t_result;

endpackage

/* rtl/core/rot_chan_bank.sv */
// Per-channel rule and limiter timing registers, one read and one write port.
module rot_chan_bank import rot_pkg::*; #(
    parameter int CHANNELS = 16,
    parameter int CH_W     = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [CH_W-1:0] i_rd_idx,
    output t_chan_rec       o_rd_rec,
    input  logic            i_we,
    input  logic [CH_W-1:0] i_wr_idx,
    input  t_chan_rec       i_wr_rec
);

    t_chan_rec r_rec [CHANNELS];

    always_comb begin
        if (32'(i_rd_idx) < CHANNELS) begin
            o_rd_rec = r_rec[i_rd_idx];
        end else begin
            o_rd_rec = REC_RESET;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_rec[i] <= REC_RESET;
            end
        end else if (i_we && (32'(i_wr_idx) < CHANNELS)) begin
            r_rec[i_wr_idx] <= i_wr_rec;
        end
    end

endmodule

/* rtl/core/rot_board_bank.sv */
// Relay shadow bytes and bus health flags, one entry per expander board.
module rot_board_bank import rot_pkg::*; #(
    parameter int BOARDS = 2,
    parameter int BD_W   = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [BD_W-1:0]           i_rd_idx,
    output logic [BITS_PER_BOARD-1:0] o_shadow,
    output logic                      o_healthy,
    input  logic                      i_we,
    input  logic [BD_W-1:0]           i_wr_idx,
    input  logic [BITS_PER_BOARD-1:0] i_shadow,
    input  logic                      i_healthy
);

    logic [BITS_PER_BOARD-1:0] r_shadow  [BOARDS];
    logic                      r_healthy [BOARDS];

    always_comb begin
        if (32'(i_rd_idx) < BOARDS) begin
            o_shadow  = r_shadow[i_rd_idx];
            o_healthy = r_healthy[i_rd_idx];
        end else begin
            o_shadow  = '0;
            o_healthy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BOARDS; i++) begin
                r_shadow[i]  <= '0;
                r_healthy[i] <= 1'b0;
            end
        end else if (i_we && (32'(i_wr_idx) < BOARDS)) begin
            r_shadow[i_wr_idx]  <= i_shadow;
            r_healthy[i_wr_idx] <= i_healthy;
        end
    end

endmodule

/* rtl/core/rot_step_eval.sv */
// Decision logic for one item: limit checks, warning and trip timing, relay drive.
module rot_step_eval import rot_pkg::*; #(
    parameter int CHANNELS = 16,
    parameter int BOARDS   = 2
) (
    input  t_item                     i_item,
    input  t_cfg                      i_cfg,
    input  t_chan_rec                 i_rec,
    input  logic [BITS_PER_BOARD-1:0] i_shadow,
    input  logic                      i_healthy,
    output t_update                   o_upd,
    output t_result                   o_res
);

    logic                      ch_ok;
    logic                      bd_ok;
    logic [BITS_PER_BOARD-1:0] mask;
    logic                      over;
    logic [31:0]               grace;
    logic [31:0]               trip;
    logic [31:0]               start;
    logic                      new_warn;
    logic                      trip_hit;
    logic                      drive_req;
    logic                      drive_closed;
    logic [BITS_PER_BOARD-1:0] new_shadow;
    logic                      new_healthy;
    t_chan_rec                 nrec;

    assign ch_ok = 32'(i_item.channel) < CHANNELS;
    assign bd_ok = 32'(i_item.channel[4:3]) < BOARDS;
    assign mask  = BITS_PER_BOARD'(1) << i_item.channel[2:0];

    // Limit checks; a negative limit is off.
    assign over = (!i_rec.energy_limit[31] &&
                   (i_item.energy_wh > 32'(i_rec.energy_limit))) ||
                  (!i_rec.power_limit[24] &&
                   ({1'b0, i_item.power_w} > 25'(i_rec.power_limit)));

    assign grace = (i_rec.grace_ms != '0) ? i_rec.grace_ms : i_cfg.default_grace_ms;
    assign trip  = (i_rec.trip_ms != '0) ? i_rec.trip_ms : i_cfg.default_trip_ms;
    // A zero mark means the excess has not been timed yet.
    assign start = (i_rec.exceed_start == '0) ? i_item.now_ms : i_rec.exceed_start;
    assign new_warn = !i_rec.warned && ((i_item.now_ms - start) >= grace);
    // A warning raised now has zero elapsed trip time.
    assign trip_hit = new_warn ? (trip == '0)
                    : (i_rec.warned && ((i_item.now_ms - i_rec.warn_start) >= trip));

    always_comb begin
        o_res        = '0;
        nrec         = i_rec;
        o_upd.chan_we = 1'b0;
        drive_req    = 1'b0;
        drive_closed = 1'b0;

        if (i_item.func == FUNC_UNUSED) begin
            o_res.status = STATUS_IGNORED;
        end else if (!ch_ok) begin
            o_res.status = STATUS_BAD_CH;
        end else begin
            o_res.bus_board = i_item.channel[3];
            priority if (i_item.func == FUNC_RULE) begin
                nrec.energy_limit = i_item.energy_limit;
                nrec.power_limit  = i_item.power_limit;
                nrec.grace_ms     = i_item.grace_ms;
                nrec.trip_ms      = i_item.trip_ms;
                nrec.tripped      = 1'b0;
                nrec.warned       = 1'b0;
                nrec.exceed_start = '0;
                nrec.warn_start   = '0;
                o_upd.chan_we     = 1'b1;
            end else if (i_item.func == FUNC_SWITCH) begin
                drive_req    = 1'b1;
                drive_closed = i_item.switch_closed;
                if (!bd_ok || !i_item.bus_ack) begin
                    o_res.status = STATUS_NACK;
                end else if (i_item.switch_closed) begin
                    nrec.tripped      = 1'b0;
                    nrec.warned       = 1'b0;
                    nrec.exceed_start = '0;
                    nrec.warn_start   = '0;
                    o_upd.chan_we     = 1'b1;
                end
            end else if (i_item.channel >= i_cfg.channels_in_use) begin
                o_res.status = STATUS_IGNORED;
            end else if (!i_rec.tripped &&
                         (!i_rec.energy_limit[31] || !i_rec.power_limit[24])) begin
                o_upd.chan_we = 1'b1;
                if (!over) begin
                    nrec.warned       = 1'b0;
                    nrec.exceed_start = '0;
                    nrec.warn_start   = '0;
                end else begin
                    nrec.exceed_start = start;
                    if (new_warn) begin
                        nrec.warned         = 1'b1;
                        nrec.warn_start     = i_item.now_ms;
                        o_res.warning_event = 1'b1;
                    end
                    if (trip_hit) begin
                        drive_req = 1'b1;
                        if (bd_ok && i_item.bus_ack) begin
                            nrec.tripped     = 1'b1;
                            o_res.trip_event = 1'b1;
                        end else begin
                            o_res.status = STATUS_NACK;
                        end
                    end
                end
            end else begin
                // tripped or fully disabled channel: the reading changes nothing
            end
        end

        // Relay drive: update the shadow byte and write the whole board.
        new_shadow     = i_shadow;
        new_healthy    = i_healthy;
        o_upd.board_we = 1'b0;
        if (drive_req && bd_ok) begin
            new_shadow      = drive_closed ? (i_shadow | mask) : (i_shadow & ~mask);
            new_healthy     = i_item.bus_ack;
            o_upd.board_we  = 1'b1;
            o_res.bus_write = 1'b1;
            o_res.bus_byte  = i_cfg.active_low ? ~new_shadow : new_shadow;
        end
        o_upd.shadow   = new_shadow;
        o_upd.healthy  = new_healthy;
        o_upd.chan_rec = nrec;

        if (ch_ok && (i_item.func != FUNC_UNUSED)) begin
            o_res.channel_closed  = bd_ok && ((new_shadow & mask) != '0);
            o_res.board_ok        = bd_ok && new_healthy;
            o_res.channel_tripped = nrec.tripped;
        end
    end

endmodule

/* rtl/core/relay_overlimit_trip_bank_unit.sv */
// Relay over-limit trip bank: top level with config, input and result registers.
//
// Input channel: i_in_valid / o_in_stall with the item fields as separate ports.
// An item is a meter reading, a switch command or a channel rule load.
// Output channel: o_out_valid / i_out_stall, one result item per input item.
// Config: i_cfg_we writes register i_cfg_index with i_cfg_wdata; write only
// while no item is in flight.
// Path: an accepted item is held in the input register, and its result is then
// registered in the result register once that register can take it.
// Throughput: one item per cycle while the receiver does not stall. The channel
// record and board shadow byte are read, updated and written back as the item
// moves from the input register into the result register.
// Receiver stall: the result register holds; the item in the input register
// waits, and o_in_stall goes high while that register is full and cannot move.
// Reset (synchronous, active low): both registers empty, relays all open,
// boards unhealthy, all rules disabled, config registers at their defaults.
module relay_overlimit_trip_bank_unit import rot_pkg::*; #(
    parameter int CHANNELS = 16,
    parameter int BOARDS   = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_func,
    input  logic [4:0]         i_channel,
    input  logic               i_switch_closed,
    input  logic [31:0]        i_energy_wh,
    input  logic [23:0]        i_power_w,
    input  logic [31:0]        i_now_ms,
    input  logic               i_bus_ack,
    input  logic signed [31:0] i_energy_limit,
    input  logic signed [24:0] i_power_limit,
    input  logic [31:0]        i_grace_ms,
    input  logic [31:0]        i_trip_ms,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic               o_bus_write,
    output logic               o_bus_board,
    output logic [7:0]         o_bus_byte,
    output logic               o_channel_closed,
    output logic               o_channel_tripped,
    output logic               o_warning_event,
    output logic               o_trip_event,
    output logic               o_board_ok
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int BD_W = (BOARDS > 1) ? $clog2(BOARDS) : 1;

    t_cfg                      r_cfg;
    logic                      r_s1_valid;
    logic                      n_s1_valid;
    t_item                     r_item;
    logic                      r_out_valid;
    logic                      n_out_valid;
    t_result                   r_res;
    logic                      in_acc;
    logic                      s1_move;
    logic [CH_W+4:0]           ch_ext;
    logic [CH_W-1:0]           ch_idx;
    logic [BD_W+1:0]           bd_ext;
    logic [BD_W-1:0]           bd_idx;
    t_chan_rec                 rec;
    logic [BITS_PER_BOARD-1:0] shadow;
    logic                      healthy;
    t_update                   upd;
    t_result                   res;

    assign s1_move    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_move;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign n_s1_valid  = in_acc || (r_s1_valid && !s1_move);
    assign n_out_valid = s1_move || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid            <= 1'b0;
            r_out_valid           <= 1'b0;
            r_cfg.active_low       <= 1'b1;
            r_cfg.default_grace_ms <= 32'd30000;
            r_cfg.default_trip_ms  <= 32'd60000;
            r_cfg.channels_in_use  <= 5'd16;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_ACTIVE_LOW:    r_cfg.active_low       <= i_cfg_wdata[0];
                    CFG_DEFAULT_GRACE: r_cfg.default_grace_ms <= i_cfg_wdata;
                    CFG_DEFAULT_TRIP:  r_cfg.default_trip_ms  <= i_cfg_wdata;
                    CFG_CHANNELS_USED: r_cfg.channels_in_use  <= i_cfg_wdata[4:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= '{
                func:          i_func,
                channel:       i_channel,
                switch_closed: i_switch_closed,
                energy_wh:     i_energy_wh,
                power_w:       i_power_w,
                now_ms:        i_now_ms,
                bus_ack:       i_bus_ack,
                energy_limit:  i_energy_limit,
                power_limit:   i_power_limit,
                grace_ms:      i_grace_ms,
                trip_ms:       i_trip_ms
            };
        end
        if (s1_move) begin
            r_res <= res;
        end
    end

    // Channel c sits on bit c mod 8 of board c / 8.
    assign ch_ext = (CH_W + 5)'(r_item.channel);
    assign ch_idx = ch_ext[CH_W-1:0];
    assign bd_ext = (BD_W + 2)'(r_item.channel[4:3]);
    assign bd_idx = bd_ext[BD_W-1:0];

    rot_chan_bank #(
        .CHANNELS(CHANNELS),
        .CH_W    (CH_W)
    ) u_chan_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_idx(ch_idx),
        .o_rd_rec(rec),
        .i_we    (s1_move && upd.chan_we),
        .i_wr_idx(ch_idx),
        .i_wr_rec(upd.chan_rec)
    );

    rot_board_bank #(
        .BOARDS(BOARDS),
        .BD_W  (BD_W)
    ) u_board_bank (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (bd_idx),
        .o_shadow (shadow),
        .o_healthy(healthy),
        .i_we     (s1_move && upd.board_we),
        .i_wr_idx (bd_idx),
        .i_shadow (upd.shadow),
        .i_healthy(upd.healthy)
    );

    rot_step_eval #(
        .CHANNELS(CHANNELS),
        .BOARDS  (BOARDS)
    ) u_step_eval (
        .i_item   (r_item),
        .i_cfg    (r_cfg),
        .i_rec    (rec),
        .i_shadow (shadow),
        .i_healthy(healthy),
        .o_upd    (upd),
        .o_res    (res)
    );

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_res.status;
    assign o_bus_write       = r_res.bus_write;
    assign o_bus_board       = r_res.bus_board;
    assign o_bus_byte        = r_res.bus_byte;
    assign o_channel_closed  = r_res.channel_closed;
    assign o_channel_tripped = r_res.channel_tripped;
    assign o_warning_event   = r_res.warning_event;
    assign o_trip_event      = r_res.trip_event;
    assign o_board_ok        = r_res.board_ok;

endmodule

/* rtl/core/rot_checker.sv */
// Port-level checker for the relay over-limit trip bank, bound to the top level.
`include "assert_macros.svh"

module rot_checker import rot_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [1:0] o_status,
    input logic       o_bus_write,
    input logic [7:0] o_bus_byte,
    input logic       o_channel_closed,
    input logic       o_channel_tripped,
    input logic       o_trip_event
);

    `ROT_ASSERT(a_out_valid_holds, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid, "result dropped while stalled")
    `ROT_ASSERT(a_out_payload_holds, i_clk, i_rst_n, o_out_valid && i_out_stall |=> $stable(o_status) && $stable(o_bus_byte) && $stable(o_trip_event), "stalled result changed")
    `ROT_ASSERT(a_no_write_zero_byte, i_clk, i_rst_n, o_out_valid && !o_bus_write |-> o_bus_byte == 8'd0, "bus byte set without a write")
    `ROT_ASSERT(a_trip_consistent, i_clk, i_rst_n, o_out_valid && o_trip_event |-> o_channel_tripped && !o_channel_closed && o_bus_write && (o_status == STATUS_DONE), "trip event with inconsistent result")
    `ROT_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind relay_overlimit_trip_bank_unit rot_checker u_rot_checker (.*);
